// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/otsp_pkg.sv -----
package otsp_pkg;

   localparam int SLOT_COUNT = 32;
   localparam int SLOT_W     = 5;
   localparam int CNT_W      = SLOT_W + 1;
   localparam int TIME_W     = 32;
   localparam int AGE_W      = 16;

   localparam logic [SLOT_W-1:0] LAST_SLOT      = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [CNT_W-1:0]  SCAN_END       = CNT_W'(SLOT_COUNT);
   localparam logic [AGE_W-1:0]  LIFETIME_RESET = AGE_W'(800);

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_SWEEP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_SCAN,
      ST_ALLOC_FIN,
      ST_SWEEP_SCAN,
      ST_SWEEP_FLUSH
   } state_type;

   // set and clear requests to the live bits
   typedef struct packed {
      logic              set_en;
      logic [SLOT_W-1:0] set_idx;
      logic              clr_en;
      logic [SLOT_W-1:0] clr_idx;
   } live_cmd_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [AGE_W-1:0]  age;
      logic              evicted;
      logic              last;
   } rsp_item_type;

endpackage

// ----- rtl/otsp_ifs.sv -----
interface otsp_req_if;
   import otsp_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [TIME_W-1:0] now;

   modport source (output valid, output action, output now, input ready);
   modport sink   (input valid, input action, input now, output ready);
endinterface

interface otsp_rsp_if;
   import otsp_pkg::*;
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot;
   logic [AGE_W-1:0]  age;
   logic              evicted;
   logic              last;

   modport source (output valid, output slot, output age, output evicted, output last,
                   input ready);
   modport sink   (input valid, input slot, input age, input evicted, input last,
                   output ready);
endinterface

interface otsp_csr_if;
   import otsp_pkg::*;
   logic             valid;
   logic             ready;
   logic [AGE_W-1:0] lifetime_ms;

   modport source (output valid, output lifetime_ms, input ready);
   modport sink   (input valid, input lifetime_ms, output ready);
endinterface

// ----- rtl/oldest_evicting_timed_slot_pool_core.sv -----
// channel  | dir | transaction
// ---------+-----+-------------------------------------------------------
// req_ch   | in  | action (alloc or sweep) and now, in milliseconds
// rsp_ch   | out | slot, age, evicted, last
// csr_ch   | in  | lifetime_ms write
//
// one item at a time; alloc with a free slot goes straight to its finish state, alloc with a full pool
// first makes one pass over the start-time memory, one read per cycle
// sweep makes the same memory pass, and its reads wait while rsp_ch stalls
// a result waiting in the output register does not block the next request transaction
// synchronous reset clears the live bits at once; no clearing pass over the memory
`include "assert_macros.svh"

module oldest_evicting_timed_slot_pool_core
   import otsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   otsp_req_if.sink    req_ch,
   otsp_rsp_if.source  rsp_ch,
   otsp_csr_if.sink    csr_ch
);

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   issue_cnt_ff, issue_cnt_in;
   logic               rd_valid_ff, rd_valid_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [AGE_W-1:0]   lifetime_ff, lifetime_in;

   // payload registers
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [SLOT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0]  oldest_idx_ff, oldest_idx_in;
   logic [TIME_W-1:0]  oldest_start_ff, oldest_start_in;
   logic [SLOT_W-1:0]  pick_ff, pick_in;
   logic               evict_ff, evict_in;
   logic [SLOT_W-1:0]  pend_slot_ff, pend_slot_in;
   logic [AGE_W-1:0]   pend_age_ff, pend_age_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   // memory and live bit connections
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [SLOT_W-1:0]  mem_rd_addr;
   logic [TIME_W-1:0]  mem_rd_data;
   live_cmd_type       live_cmd;
   logic [SLOT_COUNT-1:0] live;
   logic               all_live;
   logic [SLOT_W-1:0]  first_free;

   // datapath helpers
   logic               out_free;
   logic               emit_valid;
   rsp_item_type       emit_item;
   logic [TIME_W-1:0]  age_full;
   logic               expired;
   logic               listable;
   logic               stall;
   logic               proc;
   logic               issue;
   logic               older;
   logic [SLOT_W-1:0]  best_idx;
   logic [TIME_W-1:0]  best_start;

   otsp_start_mem u_start_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (pick_ff),
      .wr_data (now_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   otsp_live u_live (
      .clock      (clock),
      .reset      (reset),
      .cmd        (live_cmd),
      .live       (live),
      .all_live   (all_live),
      .first_free (first_free)
   );

   // config port is always ready; the user must write it only while idle, the block does not enforce this
   assign csr_ch.ready = 1'b1;

   // the output register takes a new result when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // sweep: age of the slot whose start word just came out of memory
   assign age_full = now_ff - mem_rd_data;
   assign expired  = age_full >= TIME_W'(lifetime_ff);
   assign listable = rd_valid_ff && live[rd_idx_ff] && !expired;

   // alloc scan: strict compare keeps the lowest index on ties
   assign older      = (rd_idx_ff == '0) || (mem_rd_data < oldest_start_ff);
   assign best_idx   = older ? rd_idx_ff : oldest_idx_ff;
   assign best_start = older ? mem_rd_data : oldest_start_ff;

   // a listable slot must push the pending one out first; wait if the output is full
   assign stall = (state_ff == ST_SWEEP_SCAN) && listable && pend_valid_ff && !out_free;
   assign proc  = rd_valid_ff && !stall;
   assign issue = (issue_cnt_ff != SCAN_END) && (!rd_valid_ff || proc);

   // the memory is written only when an alloc finishes and read only in scans,
   // so read and write of the same entry never overlap
   always_comb begin
      state_in        = state_ff;
      issue_cnt_in    = issue_cnt_ff;
      rd_valid_in     = rd_valid_ff;
      rd_idx_in       = rd_idx_ff;
      pend_valid_in   = pend_valid_ff;
      pend_slot_in    = pend_slot_ff;
      pend_age_in     = pend_age_ff;
      now_in          = now_ff;
      oldest_idx_in   = oldest_idx_ff;
      oldest_start_in = oldest_start_ff;
      pick_in         = pick_ff;
      evict_in        = evict_ff;
      req_ch.ready    = 1'b0;
      emit_valid      = 1'b0;
      emit_item       = '{slot: pend_slot_ff, age: pend_age_ff, evicted: 1'b0, last: 1'b0};
      mem_rd_en       = 1'b0;
      mem_rd_addr     = issue_cnt_ff[SLOT_W-1:0];
      mem_wr_en       = 1'b0;
      live_cmd        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               now_in        = req_ch.now;
               issue_cnt_in  = '0;
               rd_valid_in   = 1'b0;
               pend_valid_in = 1'b0;
               if (req_ch.action == ACT_ALLOC) begin
                  if (all_live) begin
                     state_in = ST_ALLOC_SCAN;
                  end else begin
                     pick_in  = first_free;
                     evict_in = 1'b0;
                     state_in = ST_ALLOC_FIN;
                  end
               end else begin
                  state_in = ST_SWEEP_SCAN;
               end
            end
         end

         ST_ALLOC_SCAN: begin
            // one start word per cycle, running minimum kept in registers
            if (issue) begin
               mem_rd_en    = 1'b1;
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               rd_idx_in    = issue_cnt_ff[SLOT_W-1:0];
            end
            rd_valid_in = issue;
            if (proc) begin
               oldest_idx_in   = best_idx;
               oldest_start_in = best_start;
               if (rd_idx_ff == LAST_SLOT) begin
                  pick_in  = best_idx;
                  evict_in = 1'b1;
                  state_in = ST_ALLOC_FIN;
               end
            end
         end

         ST_ALLOC_FIN: begin
            emit_valid = 1'b1;
            emit_item  = '{slot: pick_ff, age: '0, evicted: evict_ff, last: 1'b1};
            if (out_free) begin
               mem_wr_en        = 1'b1;
               live_cmd.set_en  = 1'b1;
               live_cmd.set_idx = pick_ff;
               state_in         = ST_IDLE;
            end
         end

         ST_SWEEP_SCAN: begin
            if (issue) begin
               mem_rd_en    = 1'b1;
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               rd_idx_in    = issue_cnt_ff[SLOT_W-1:0];
            end
            rd_valid_in = issue || (rd_valid_ff && !proc);
            if (proc) begin
               if (live[rd_idx_ff] && expired) begin
                  live_cmd.clr_en  = 1'b1;
                  live_cmd.clr_idx = rd_idx_ff;
               end
               // hold one listed slot back so the final one can carry last
               if (listable) begin
                  emit_valid    = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_slot_in  = rd_idx_ff;
                  pend_age_in   = age_full[AGE_W-1:0];
               end
               if (rd_idx_ff == LAST_SLOT) begin
                  state_in = ST_SWEEP_FLUSH;
               end
            end
         end

         ST_SWEEP_FLUSH: begin
            if (pend_valid_ff) begin
               emit_valid     = 1'b1;
               emit_item.last = 1'b1;
               if (out_free) begin
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = emit_item;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // lifetime register
   always_comb begin
      lifetime_in = lifetime_ff;
      if (csr_ch.valid) begin
         lifetime_in = csr_ch.lifetime_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_cnt_ff  <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         lifetime_ff   <= LIFETIME_RESET;
      end else begin
         state_ff      <= state_in;
         issue_cnt_ff  <= issue_cnt_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         lifetime_ff   <= lifetime_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff          <= now_in;
      rd_idx_ff       <= rd_idx_in;
      oldest_idx_ff   <= oldest_idx_in;
      oldest_start_ff <= oldest_start_in;
      pick_ff         <= pick_in;
      evict_ff        <= evict_in;
      pend_slot_ff    <= pend_slot_in;
      pend_age_ff     <= pend_age_in;
      rsp_item_ff     <= rsp_item_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.slot    = rsp_item_ff.slot;
   assign rsp_ch.age     = rsp_item_ff.age;
   assign rsp_ch.evicted = rsp_item_ff.evicted;
   assign rsp_ch.last    = rsp_item_ff.last;

   // eviction scan only runs on a full pool, and the pool stays full during it
   `ASSERT_IMPLIES(a_scan_full, clock, reset, state_ff == ST_ALLOC_SCAN, all_live, "alloc scan with free slot")
   // an eviction result is an alloc result: last set, zero age
   `ASSERT_IMPLIES(a_evict_shape, clock, reset, rsp_valid_ff && rsp_item_ff.evicted, rsp_item_ff.last && (rsp_item_ff.age == '0), "bad eviction result")
   // nothing is held back once the block is idle
   `ASSERT_IMPLIES(a_idle_no_pend, clock, reset, state_ff == ST_IDLE, !pend_valid_ff && !rd_valid_ff, "leftover scan state in idle")

endmodule

// ----- rtl/otsp_start_mem.sv -----
module otsp_start_mem
   import otsp_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  logic [TIME_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [TIME_W-1:0] rd_data
);

   logic [TIME_W-1:0] mem [SLOT_COUNT];
   logic [TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/otsp_live.sv -----
module otsp_live
   import otsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  live_cmd_type          cmd,
   output logic [SLOT_COUNT-1:0] live,
   output logic                  all_live,
   output logic [SLOT_W-1:0]     first_free
);

   logic [SLOT_COUNT-1:0] live_ff;
   logic [SLOT_COUNT-1:0] live_in;

   always_comb begin
      live_in = live_ff;
      if (cmd.clr_en) begin
         live_in[cmd.clr_idx] = 1'b0;
      end
      if (cmd.set_en) begin
         live_in[cmd.set_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   // lowest inactive slot wins
   always_comb begin
      first_free = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            first_free = SLOT_W'(i);
         end
      end
   end

   assign live     = live_ff;
   assign all_live = &live_ff;

endmodule
